// ===== rtl/vfcm_pkg.sv =====
`default_nettype none
package vfcm_pkg;

  localparam int DEF_GRID_SIZE = 16;

  localparam int OP_W    = 2;
  localparam int COORD_W = 4;
  localparam int INDEX_W = 12;
  localparam int FACE_W  = 3;
  localparam int VERT_W  = 17;
  localparam int SEL_W   = 3;
  localparam int NFACES  = 6;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd2;

  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

  // Read select: the center voxel first, then one code per face in output order.
  localparam logic [SEL_W-1:0] SEL_CENTER = 3'd0;
  localparam logic [SEL_W-1:0] SEL_TOP    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_BOTTOM = 3'd2;
  localparam logic [SEL_W-1:0] SEL_RIGHT  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_LEFT   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_FRONT  = 3'd5;
  localparam logic [SEL_W-1:0] SEL_BACK   = 3'd6;

  localparam logic [VERT_W-1:0] VERT_STEP = 17'd4;

  typedef struct packed {
    logic             load_wr;
    logic             query_start;
    logic             begin_clr;
    logic             rd_en;
    logic [SEL_W-1:0] rd_sel;
    logic             emit;
  } vfcm_cmd_t;

  typedef struct packed {
    logic emit_last;
  } vfcm_status_t;

endpackage
`default_nettype wire

// ===== rtl/voxel_face_culling_mesher_core.sv =====
// Channel   Handshake          Ports
// input     start, busy        in_op, in_pos_x, in_pos_y, in_pos_z, in_solid
// result    out_valid strobe   out_voxel_index, out_face, out_base_vertex,
//                              out_face_valid, out_last
//
// A word is taken at a clock edge with start high and busy low.
// Load and begin never raise busy.
// A query reads the voxel and its six neighbors from the single-port grid
// memory, one read per cycle, and then sends one record per cycle, 1 to 6
// records in all; busy stays high through the read, wait and emit states.
// Each record shows on the result ports for one cycle under out_valid;
// the receiver cannot stall. Reset (synchronous, active low) clears the
// controller and the vertex counter; the grid is not cleared.
`default_nettype none
module voxel_face_culling_mesher_core #(
  parameter int GRID_SIZE = vfcm_pkg::DEF_GRID_SIZE
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [vfcm_pkg::OP_W-1:0]    in_op,
  input  wire logic [vfcm_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic [vfcm_pkg::COORD_W-1:0] in_pos_y,
  input  wire logic [vfcm_pkg::COORD_W-1:0] in_pos_z,
  input  wire logic                         in_solid,
  output logic                              out_valid,
  output logic [vfcm_pkg::INDEX_W-1:0]      out_voxel_index,
  output logic [vfcm_pkg::FACE_W-1:0]       out_face,
  output logic [vfcm_pkg::VERT_W-1:0]       out_base_vertex,
  output logic                              out_face_valid,
  output logic                              out_last
);
  import vfcm_pkg::*;

  vfcm_cmd_t    cmd;
  vfcm_status_t status;

  vfcm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_op),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  vfcm_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .pos_x           (in_pos_x),
    .pos_y           (in_pos_y),
    .pos_z           (in_pos_z),
    .solid           (in_solid),
    .out_valid       (out_valid),
    .out_voxel_index (out_voxel_index),
    .out_face        (out_face),
    .out_base_vertex (out_base_vertex),
    .out_face_valid  (out_face_valid),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// ===== rtl/vfcm_ctrl.sv =====
`default_nettype none
module vfcm_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [vfcm_pkg::OP_W-1:0] op,
  output logic                           busy,
  output vfcm_pkg::vfcm_cmd_t            cmd,
  input  wire vfcm_pkg::vfcm_status_t    status
);
  import vfcm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic             accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt       = state_r;
    sel_nxt         = sel_r;
    cmd.load_wr     = accept && (op == OP_LOAD);
    cmd.query_start = accept && (op == OP_QUERY);
    cmd.begin_clr   = accept && (op == OP_BEGIN);
    cmd.rd_en       = (state_r == ST_READ);
    cmd.rd_sel      = sel_r;
    cmd.emit        = (state_r == ST_EMIT);
    case (state_r)
      ST_IDLE: begin
        if (cmd.query_start) begin
          state_nxt = ST_READ;
          sel_nxt   = SEL_CENTER;
        end
      end
      ST_READ: begin
        sel_nxt = sel_r + 3'd1;
        if (sel_r == SEL_BACK) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_CENTER;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vfcm_dp.sv =====
`default_nettype none
module vfcm_dp #(
  parameter int GRID_SIZE = vfcm_pkg::DEF_GRID_SIZE
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire vfcm_pkg::vfcm_cmd_t          cmd,
  output vfcm_pkg::vfcm_status_t            status,
  input  wire logic [vfcm_pkg::COORD_W-1:0] pos_x,
  input  wire logic [vfcm_pkg::COORD_W-1:0] pos_y,
  input  wire logic [vfcm_pkg::COORD_W-1:0] pos_z,
  input  wire logic                         solid,
  output logic                              out_valid,
  output logic [vfcm_pkg::INDEX_W-1:0]      out_voxel_index,
  output logic [vfcm_pkg::FACE_W-1:0]       out_face,
  output logic [vfcm_pkg::VERT_W-1:0]       out_base_vertex,
  output logic                              out_face_valid,
  output logic                              out_last
);
  import vfcm_pkg::*;

  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = ((AW > INDEX_W) ? AW : INDEX_W) + 4;
  localparam logic [AW-1:0] STEP_Z = AW'(GRID_SIZE);
  localparam logic [AW-1:0] STEP_Y = AW'(GRID_SIZE * GRID_SIZE);
  localparam logic [LW-1:0] MUL_Z  = LW'(GRID_SIZE);
  localparam logic [LW-1:0] MUL_Y  = LW'(GRID_SIZE * GRID_SIZE);

  logic mem [DEPTH];
  logic mem_q_r;

  logic [LW-1:0]      lin;
  logic               in_inside;
  logic [AW-1:0]      in_addr;

  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic [AW-1:0]      addr_r;
  logic               inside_r;
  logic [INDEX_W-1:0] vidx_r;

  logic [AW-1:0]      rd_addr;
  logic               rd_oob;
  logic [AW-1:0]      mem_addr;

  logic               cap_en_r;
  logic [SEL_W-1:0]   cap_sel_r;
  logic               cap_oob_r;
  logic               center_solid_r;
  logic [NFACES-1:0]  rem_r;
  logic [VERT_W-1:0]  cnt_r;

  logic [NFACES-1:0]  pick;
  logic [FACE_W-1:0]  pick_face;
  logic [NFACES-1:0]  rest;
  logic               any_face;

  assign lin = LW'(pos_x) + LW'(pos_z) * MUL_Z + LW'(pos_y) * MUL_Y;
  assign in_inside = (pos_x < GRID_SIZE) && (pos_y < GRID_SIZE) && (pos_z < GRID_SIZE);
  assign in_addr   = in_inside ? lin[AW-1:0] : '0;

  // Neighbor address and whether that neighbor lies outside the grid.
  always_comb begin
    rd_addr = addr_r;
    rd_oob  = 1'b0;
    case (cmd.rd_sel)
      SEL_CENTER: begin
        rd_addr = addr_r;
        rd_oob  = 1'b0;
      end
      SEL_TOP: begin
        rd_oob  = !((y_r + 5'd1) < GRID_SIZE);
        rd_addr = rd_oob ? addr_r : addr_r + STEP_Y;
      end
      SEL_BOTTOM: begin
        rd_oob  = (y_r == '0);
        rd_addr = rd_oob ? addr_r : addr_r - STEP_Y;
      end
      SEL_RIGHT: begin
        rd_oob  = !((x_r + 5'd1) < GRID_SIZE);
        rd_addr = rd_oob ? addr_r : addr_r + AW'(1);
      end
      SEL_LEFT: begin
        rd_oob  = (x_r == '0);
        rd_addr = rd_oob ? addr_r : addr_r - AW'(1);
      end
      SEL_FRONT: begin
        rd_oob  = !((z_r + 5'd1) < GRID_SIZE);
        rd_addr = rd_oob ? addr_r : addr_r + STEP_Z;
      end
      SEL_BACK: begin
        rd_oob  = (z_r == '0);
        rd_addr = rd_oob ? addr_r : addr_r - STEP_Z;
      end
      default: begin
        rd_addr = addr_r;
        rd_oob  = 1'b1;
      end
    endcase
  end

  // Single port: loads write only while idle, queries read only while busy.
  assign mem_addr = cmd.rd_en ? rd_addr : in_addr;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_inside) begin
      mem[mem_addr] <= solid;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // Lowest remaining visible face goes out next.
  always_comb begin
    pick      = '0;
    pick_face = FACE_TOP;
    for (int i = NFACES - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        pick      = NFACES'(1) << i;
        pick_face = FACE_W'(i);
      end
    end
  end

  assign rest             = rem_r & ~pick;
  assign any_face         = (rem_r != '0);
  assign status.emit_last = (rest == '0);

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      x_r      <= pos_x;
      y_r      <= pos_y;
      z_r      <= pos_z;
      addr_r   <= in_addr;
      inside_r <= in_inside;
      vidx_r   <= lin[INDEX_W-1:0];
    end
    cap_sel_r <= cmd.rd_sel;
    cap_oob_r <= rd_oob;
    if (cap_en_r) begin
      if (cap_sel_r == SEL_CENTER) begin
        center_solid_r <= inside_r && mem_q_r;
      end else begin
        rem_r[cap_sel_r - 3'd1] <= center_solid_r && (cap_oob_r || !mem_q_r);
      end
    end else if (cmd.emit) begin
      rem_r <= rest;
    end
    if (cmd.emit) begin
      out_voxel_index <= vidx_r;
      out_face        <= pick_face;
      out_base_vertex <= any_face ? cnt_r : '0;
      out_face_valid  <= any_face;
      out_last        <= status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r  <= 1'b0;
      out_valid <= 1'b0;
      cnt_r     <= '0;
    end else begin
      cap_en_r  <= cmd.rd_en;
      out_valid <= cmd.emit;
      if (cmd.begin_clr) begin
        cnt_r <= '0;
      end else if (cmd.emit && any_face) begin
        cnt_r <= cnt_r + VERT_STEP;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/mesher_face_checker.sv =====
module mesher_face_checker #(
  parameter int GRID = vfcm_pkg::DEF_GRID_SIZE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [vfcm_pkg::OP_W-1:0]    in_op,
  input  logic [vfcm_pkg::COORD_W-1:0] in_pos_x,
  input  logic [vfcm_pkg::COORD_W-1:0] in_pos_y,
  input  logic [vfcm_pkg::COORD_W-1:0] in_pos_z,
  input  logic                         in_solid,
  input  logic                         out_valid,
  input  logic [vfcm_pkg::INDEX_W-1:0] out_voxel_index,
  input  logic [vfcm_pkg::FACE_W-1:0]  out_face,
  input  logic [vfcm_pkg::VERT_W-1:0]  out_base_vertex,
  input  logic                         out_face_valid,
  input  logic                         out_last,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vfcm_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [FACE_W-1:0]  face;
    logic [VERT_W-1:0]  base;
    logic               valid;
    logic               last;
  } face_rec_t;

  bit                solid_map [GRID*GRID*GRID];
  logic [VERT_W-1:0] vertex_next;
  face_rec_t         faces_due [$];
  int                mismatches = 0;

  function automatic int cell_of(input int x, input int y, input int z);
    return x + z * GRID + y * GRID * GRID;
  endfunction

  // A side is open when the neighbor is air or falls outside the grid.
  function automatic bit side_open(input int x, input int y, input int z,
                                   input logic [FACE_W-1:0] face);
    int nx;
    int ny;
    int nz;
    nx = x;
    ny = y;
    nz = z;
    case (face)
      FACE_TOP:    ny = y + 1;
      FACE_BOTTOM: ny = y - 1;
      FACE_RIGHT:  nx = x + 1;
      FACE_LEFT:   nx = x - 1;
      FACE_FRONT:  nz = z + 1;
      FACE_BACK:   nz = z - 1;
      default: ;
    endcase
    if (nx < 0 || ny < 0 || nz < 0 || nx >= GRID || ny >= GRID || nz >= GRID)
      return 1'b1;
    return !solid_map[cell_of(nx, ny, nz)];
  endfunction

  task automatic predict_faces(input int x, input int y, input int z);
    face_rec_t          found [$];
    face_rec_t          rec;
    logic [FACE_W-1:0]  face;
    logic [INDEX_W-1:0] index;
    bit                 in_grid;
    int                 f;
    index   = INDEX_W'(cell_of(x, y, z));
    in_grid = x < GRID && y < GRID && z < GRID;
    if (in_grid && solid_map[cell_of(x, y, z)]) begin
      for (f = 0; f < NFACES; f++) begin
        face = FACE_W'(f);
        if (side_open(x, y, z, face)) begin
          rec = '{index, face, vertex_next, 1'b1, 1'b0};
          found = {found, rec};
          vertex_next = vertex_next + VERT_STEP;
        end
      end
    end
    // Air or a fully buried voxel still answers with a single empty record.
    if (found.size() == 0) begin
      rec = '{index, FACE_TOP, '0, 1'b0, 1'b0};
      found = {found, rec};
    end
    foreach (found[i]) begin
      rec = found[i];
      rec.last = (i == found.size() - 1);
      faces_due = {faces_due, rec};
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: out_%s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    face_rec_t want;
    if (!rst_n) begin
      faces_due.delete();
      vertex_next = '0;
    end else begin
      if (out_valid) begin
        if (faces_due.size() == 0) begin
          mismatches++;
          $display("%0t: record expected none, got index %0d face %0d base %0d",
                   $time, out_voxel_index, out_face, out_base_vertex);
        end else begin
          want = faces_due.pop_front();
          check_field("voxel_index", want.index, out_voxel_index);
          check_field("face", want.face, out_face);
          check_field("base_vertex", want.base, out_base_vertex);
          check_field("face_valid", want.valid, out_face_valid);
          check_field("last", want.last, out_last);
        end
      end
      if (start && !busy) begin
        case (in_op)
          OP_LOAD: begin
            if (in_pos_x < GRID && in_pos_y < GRID && in_pos_z < GRID)
              solid_map[cell_of(in_pos_x, in_pos_y, in_pos_z)] = in_solid;
          end
          OP_QUERY: predict_faces(in_pos_x, in_pos_y, in_pos_z);
          OP_BEGIN: vertex_next = '0;
          default: ;
        endcase
      end
    end
    errors  <= mismatches;
    pending <= faces_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vfcm_pkg::*;

  localparam int                GRID         = DEF_GRID_SIZE;
  localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
  localparam int                WORD_TARGET  = 330;
  localparam int                STALL_LIMIT  = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_op;
  logic [COORD_W-1:0]   in_pos_x;
  logic [COORD_W-1:0]   in_pos_y;
  logic [COORD_W-1:0]   in_pos_z;
  logic                 in_solid;
  logic                 out_valid;
  logic [INDEX_W-1:0]   out_voxel_index;
  logic [FACE_W-1:0]    out_face;
  logic [VERT_W-1:0]    out_base_vertex;
  logic                 out_face_valid;
  logic                 out_last;
  int                   fail_count;
  int                   records_pending;
  int                   stall_cycles = 0;
  int                   words_sent = 0;
  bit                   sender_gaps = 1'b1;
  bit                   loaded [GRID*GRID*GRID];

  voxel_face_culling_mesher_core #(.GRID_SIZE(GRID)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_solid        (in_solid),
    .out_valid       (out_valid),
    .out_voxel_index (out_voxel_index),
    .out_face        (out_face),
    .out_base_vertex (out_base_vertex),
    .out_face_valid  (out_face_valid),
    .out_last        (out_last)
  );

  mesher_face_checker #(.GRID(GRID)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_solid        (in_solid),
    .out_valid       (out_valid),
    .out_voxel_index (out_voxel_index),
    .out_face        (out_face),
    .out_base_vertex (out_base_vertex),
    .out_face_valid  (out_face_valid),
    .out_last        (out_last),
    .errors          (fail_count),
    .pending         (records_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("voxel_face_culling_mesher_core verification failed");
    $finish;
  end

  function automatic int cell_of(input int x, input int y, input int z);
    return x + z * GRID + y * GRID * GRID;
  endfunction

  // Edges and a small hot region get most of the picks so neighbors get reused.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return (r == 0) ? 0 : GRID - 1;
    if (r < 6)
      return $urandom_range(5, 8);
    return $urandom_range(0, GRID - 1);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input int x, input int y,
                           input int z, input logic s);
    if (sender_gaps)
      while ($urandom_range(0, 99) < 11) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start    <= 1'b1;
    in_op    <= op;
    in_pos_x <= COORD_W'(x);
    in_pos_y <= COORD_W'(y);
    in_pos_z <= COORD_W'(z);
    in_solid <= s;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD)
      loaded[cell_of(x, y, z)] = 1'b1;
    if (op != OP_UNUSED)
      words_sent++;
  endtask

  // Every cell a query touches must have been loaded; some get rewritten anyway.
  task automatic refresh_cell(input int x, input int y, input int z);
    if (!loaded[cell_of(x, y, z)] || $urandom_range(0, 99) < 15)
      send_word(OP_LOAD, x, y, z, $urandom_range(0, 99) < 75);
  endtask

  task automatic query_in_context(input int x, input int y, input int z);
    refresh_cell(x, y, z);
    if (y < GRID - 1) refresh_cell(x, y + 1, z);
    if (y > 0)        refresh_cell(x, y - 1, z);
    if (x < GRID - 1) refresh_cell(x + 1, y, z);
    if (x > 0)        refresh_cell(x - 1, y, z);
    if (z < GRID - 1) refresh_cell(x, y, z + 1);
    if (z > 0)        refresh_cell(x, y, z - 1);
    send_word(OP_QUERY, x, y, z, $urandom_range(0, 1));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (records_pending != 0);
  endtask

  initial begin
    int pick;
    bit paused;
    paused   = 1'b0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_op    <= OP_LOAD;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    in_solid <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Corner voxel with air all around shows all six faces.
    send_word(OP_BEGIN, GRID - 1, GRID - 1, GRID - 1, 1'b1);
    send_word(OP_LOAD, 0, 0, 0, 1'b1);
    send_word(OP_LOAD, 1, 0, 0, 1'b0);
    send_word(OP_LOAD, 0, 1, 0, 1'b0);
    send_word(OP_LOAD, 0, 0, 1, 1'b0);
    send_word(OP_QUERY, 0, 0, 0, 1'b0);
    // Far corner: the grid border counts as open, inner neighbors hide faces.
    send_word(OP_LOAD, GRID - 1, GRID - 1, GRID - 1, 1'b1);
    send_word(OP_LOAD, GRID - 2, GRID - 1, GRID - 1, 1'b1);
    send_word(OP_LOAD, GRID - 1, GRID - 2, GRID - 1, 1'b1);
    send_word(OP_LOAD, GRID - 1, GRID - 1, GRID - 2, 1'b1);
    send_word(OP_QUERY, GRID - 1, GRID - 1, GRID - 1, 1'b1);
    // Fully enclosed voxel gives the empty record.
    send_word(OP_LOAD, 8, 8, 8, 1'b1);
    for (int d = 7; d <= 9; d += 2) begin
      send_word(OP_LOAD, d, 8, 8, 1'b1);
      send_word(OP_LOAD, 8, d, 8, 1'b1);
      send_word(OP_LOAD, 8, 8, d, 1'b1);
    end
    send_word(OP_QUERY, 8, 8, 8, 1'b1);
    // Query on air.
    send_word(OP_LOAD, 0, 0, 0, 1'b0);
    send_word(OP_QUERY, 0, 0, 0, 1'b1);
    send_word(OP_UNUSED, GRID - 1, GRID - 1, GRID - 1, 1'b1);
    send_word(OP_BEGIN, 0, 0, 0, 1'b0);
    send_word(OP_QUERY, GRID - 1, GRID - 1, GRID - 1, 1'b0);

    while (words_sent < WORD_TARGET) begin
      if (!paused && words_sent >= 150) begin
        wait_drained();
        paused = 1'b1;
      end
      sender_gaps = !(words_sent >= 200 && words_sent < 270);
      pick = $urandom_range(0, 99);
      if (pick < 64)
        query_in_context(pick_coord(), pick_coord(), pick_coord());
      else if (pick < 86)
        send_word(OP_LOAD, pick_coord(), pick_coord(), pick_coord(),
                  $urandom_range(0, 1));
      else if (pick < 94)
        send_word(OP_BEGIN, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                  $urandom_range(0, GRID - 1), $urandom_range(0, 1));
      else
        send_word(OP_UNUSED, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                  $urandom_range(0, GRID - 1), $urandom_range(0, 1));
    end
    sender_gaps = 1'b1;

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("voxel_face_culling_mesher_core verification clean");
    else
      $display("voxel_face_culling_mesher_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vfcm_pkg.sv
rtl/vfcm_ctrl.sv
rtl/vfcm_dp.sv
rtl/voxel_face_culling_mesher_core.sv
sim/mesher_face_checker.sv
sim/tb_top.sv
